[rtl/lcts_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lcts_pkg;

  localparam int TIME_BITS     = 48;
  localparam int UNIT_BITS     = 32;
  localparam int CYCLE_BITS    = 16;
  localparam int LEAP_LEN_BITS = 32;
  localparam int COUNT_BITS    = 16;
  localparam int INDEX_BITS    = 32;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_INDEX_BITS = 2;

  // leap extra is leap_unit_length * leap_count
  localparam int EXTRA_BITS = LEAP_LEN_BITS + COUNT_BITS;
  // full cycle length: cycle * unit length + extra
  localparam int FULL_BITS  = EXTRA_BITS + 1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_UNIT_LENGTH      = 2'd0,
    REG_LEAP_CYCLE       = 2'd1,
    REG_LEAP_UNIT_LENGTH = 2'd2,
    REG_LEAP_COUNT       = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_SPLIT   = 1'b0,
    OP_COMPOSE = 1'b1
  } opcode_t;

  typedef struct packed {
    logic                  opcode;
    logic [TIME_BITS-1:0]  time_value;
    logic [INDEX_BITS-1:0] unit_count;
  } in_word_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]  boundary_time;
    logic [INDEX_BITS-1:0] unit_index;
    logic                  in_leap_unit;
  } out_word_t;

endpackage

`default_nettype wire

[rtl/leap_cycle_time_split.sv]
`timescale 1ns / 1ps
`default_nettype none

// Splits a tick count into leap-cycle units (start time, unit index, leap flag) or composes
// a unit count into ticks. One word is processed at a time. Let D be the larger of
// TIME_BITS and 32. A 16-step shift-add pass builds the cycle length, a radix-2 restoring
// divider takes D steps, a 16-step divider finds the unit inside the cycle (only for a
// split that lands in an ordinary unit), and a D-step shift-add pass forms the start
// time and index. A result still waiting to be read holds the finished word in its
// last step. The next word is taken the cycle after the result enters the output register,
// even before it is read. The user must write the registers only while no word is in
// flight; the block itself does not enforce this.

module leap_cycle_time_split (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [lcts_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [lcts_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire lcts_pkg::in_word_t                  in_word,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output lcts_pkg::out_word_t                      out_word
);

  localparam int TB         = lcts_pkg::TIME_BITS;
  localparam int UB         = lcts_pkg::UNIT_BITS;
  localparam int CB         = lcts_pkg::CYCLE_BITS;
  localparam int EB         = lcts_pkg::EXTRA_BITS;
  localparam int FB         = lcts_pkg::FULL_BITS;
  localparam int IB         = lcts_pkg::INDEX_BITS;
  localparam int DIV_BITS   = (TB > IB) ? TB : IB;
  localparam int WIDE_BITS  = (TB > FB) ? TB : FB;
  localparam int CNT_BITS   = $clog2(DIV_BITS);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_PREP   = 9'b000000010,
    ST_SETUP  = 9'b000000100,
    ST_DIV    = 9'b000001000,
    ST_LOAD   = 9'b000010000,
    ST_WITHIN = 9'b000100000,
    ST_ARM    = 9'b001000000,
    ST_MUL    = 9'b010000000,
    ST_FIN    = 9'b100000000
  } state_t;

  state_t state;

  logic [UB-1:0] unit_length;
  logic [CB-1:0] cycle_units;
  logic [lcts_pkg::LEAP_LEN_BITS-1:0] leap_unit_length;
  logic [lcts_pkg::COUNT_BITS-1:0]    leap_count;

  logic [UB-1:0] len_c;
  logic [CB-1:0] cyc_c;
  logic [lcts_pkg::COUNT_BITS-1:0] lc_c;

  logic          op;
  logic          tzero;
  logic          leap;
  logic [IB-1:0] count;
  logic [CNT_BITS-1:0] cnt;

  logic [lcts_pkg::COUNT_BITS-1:0] pa_x;
  logic [EB-1:0] pa_y;
  logic [EB-1:0] extra;
  logic [CB-1:0] pb_x;
  logic [EB-1:0] pb_y;
  logic [EB-1:0] cl;
  logic [EB-1:0] ord;

  logic [FB-1:0]       div_d;
  logic [FB-1:0]       rem;
  logic [DIV_BITS-1:0] quo;
  logic [FB:0]         div_shift;
  logic [FB:0]         div_trial;

  logic [UB-1:0] wrem;
  logic [CB-1:0] wq;
  logic [UB:0]   w_shift;
  logic [UB:0]   w_trial;

  logic [TB-1:0] ma;
  logic [IB-1:0] mb_x;
  logic [TB-1:0] mb_y;
  logic [IB-1:0] mc;
  logic [TB-1:0] acc_a;
  logic [TB-1:0] acc_b;
  logic [IB-1:0] acc_c;

  logic [WIDE_BITS-1:0] ma_src;
  logic [WIDE_BITS-1:0] len_wide;
  logic                 fin_go;
  lcts_pkg::out_word_t  result;

  // zero register values behave as one
  assign len_c = (unit_length == '0) ? UB'(1) : unit_length;
  assign cyc_c = (cycle_units == '0) ? CB'(1) : cycle_units;
  assign lc_c  = (leap_count == '0) ? lcts_pkg::COUNT_BITS'(1) : leap_count;

  assign in_ready = (state == ST_IDLE);

  assign div_shift = {rem, quo[DIV_BITS-1]};
  assign div_trial = div_shift - {1'b0, div_d};
  assign w_shift   = {wrem, wq[CB-1]};
  assign w_trial   = w_shift - {1'b0, len_c};

  assign ma_src   = op ? WIDE_BITS'(extra) : WIDE_BITS'(div_d);
  assign len_wide = WIDE_BITS'(len_c);

  assign fin_go = (state == ST_FIN) && (!out_valid || out_ready);

  always_comb begin
    result.boundary_time = acc_a + acc_b;
    result.unit_index    = acc_c + IB'(wq);
    result.in_leap_unit  = leap;
    if (op == lcts_pkg::OP_COMPOSE) begin
      result.unit_index   = count;
      result.in_leap_unit = 1'b0;
    end else if (tzero) begin
      result.boundary_time = '0;
      result.unit_index    = '0;
      result.in_leap_unit  = (cyc_c == CB'(1));
    end
  end

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_length      <= UB'(1);
      cycle_units      <= CB'(1);
      leap_unit_length <= '0;
      leap_count       <= lcts_pkg::COUNT_BITS'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        lcts_pkg::REG_UNIT_LENGTH:      unit_length      <= cfg_data[UB-1:0];
        lcts_pkg::REG_LEAP_CYCLE:       cycle_units      <= cfg_data[CB-1:0];
        lcts_pkg::REG_LEAP_UNIT_LENGTH: leap_unit_length <= cfg_data;
        lcts_pkg::REG_LEAP_COUNT:       leap_count       <= cfg_data[lcts_pkg::COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          if (cnt == CNT_BITS'(CB - 1)) begin
            state <= ST_SETUP;
          end
        end
        ST_SETUP: state <= ST_DIV;
        ST_DIV: begin
          if (cnt == CNT_BITS'(DIV_BITS - 1)) begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (op == lcts_pkg::OP_SPLIT && rem < FB'(ord)) begin
            state <= ST_WITHIN;
          end else begin
            state <= ST_ARM;
          end
        end
        ST_WITHIN: begin
          if (cnt == CNT_BITS'(CB - 1)) begin
            state <= ST_ARM;
          end
        end
        ST_ARM: state <= ST_MUL;
        ST_MUL: begin
          if (cnt == CNT_BITS'(DIV_BITS - 1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        op    <= in_word.opcode;
        tzero <= (in_word.time_value == '0);
        count <= in_word.unit_count;
        if (in_word.opcode == lcts_pkg::OP_COMPOSE) begin
          quo <= DIV_BITS'(in_word.unit_count);
        end else begin
          quo <= DIV_BITS'(in_word.time_value) - DIV_BITS'(1);
        end
        cnt   <= '0;
        pa_x  <= lc_c;
        pa_y  <= EB'(leap_unit_length);
        extra <= '0;
        pb_x  <= cyc_c;
        pb_y  <= EB'(len_c);
        cl    <= '0;
      end
      ST_PREP: begin
        if (pa_x[0]) begin
          extra <= extra + pa_y;
        end
        if (pb_x[0]) begin
          cl <= cl + pb_y;
        end
        pa_x <= pa_x >> 1;
        pa_y <= pa_y << 1;
        pb_x <= pb_x >> 1;
        pb_y <= pb_y << 1;
        cnt  <= cnt + CNT_BITS'(1);
      end
      ST_SETUP: begin
        if (op == lcts_pkg::OP_COMPOSE) begin
          div_d <= FB'(cyc_c);
        end else begin
          div_d <= FB'(cl) + FB'(extra);
        end
        ord <= cl - EB'(len_c);
        rem <= '0;
        cnt <= '0;
      end
      ST_DIV: begin
        if (!div_trial[FB]) begin
          rem <= div_trial[FB-1:0];
        end else begin
          rem <= div_shift[FB-1:0];
        end
        quo <= {quo[DIV_BITS-2:0], ~div_trial[FB]};
        cnt <= cnt + CNT_BITS'(1);
      end
      ST_LOAD: begin
        cnt  <= '0;
        wrem <= rem[UB+CB-1:CB];
        if (op == lcts_pkg::OP_COMPOSE) begin
          wq   <= '0;
          leap <= 1'b0;
        end else if (rem < FB'(ord)) begin
          wq   <= rem[CB-1:0];
          leap <= 1'b0;
        end else begin
          wq   <= cyc_c - CB'(1);
          leap <= 1'b1;
        end
      end
      ST_WITHIN: begin
        if (!w_trial[UB]) begin
          wrem <= w_trial[UB-1:0];
        end else begin
          wrem <= w_shift[UB-1:0];
        end
        wq  <= {wq[CB-2:0], ~w_trial[UB]};
        cnt <= cnt + CNT_BITS'(1);
      end
      ST_ARM: begin
        cnt   <= '0;
        ma    <= ma_src[TB-1:0];
        mb_x  <= (op == lcts_pkg::OP_COMPOSE) ? count : IB'(wq);
        mb_y  <= len_wide[TB-1:0];
        mc    <= IB'(cyc_c);
        acc_a <= '0;
        acc_b <= '0;
        acc_c <= '0;
      end
      ST_MUL: begin
        if (quo[0]) begin
          acc_a <= acc_a + ma;
          acc_c <= acc_c + mc;
        end
        if (mb_x[0]) begin
          acc_b <= acc_b + mb_y;
        end
        quo  <= quo >> 1;
        ma   <= ma << 1;
        mc   <= mc << 1;
        mb_x <= mb_x >> 1;
        mb_y <= mb_y << 1;
        cnt  <= cnt + CNT_BITS'(1);
      end
      ST_FIN: begin
        if (fin_go) begin
          out_word <= result;
        end
      end
      default: ;
    endcase
  end

  a_start_prep: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_PREP)
    else $error("accepted word did not start the length pass");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> div_d != '0)
    else $error("divider running with zero divisor");

  a_within_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_WITHIN |-> wrem < len_c)
    else $error("unit divider remainder out of range");

  a_compose_flag: assert property (@(posedge clk) disable iff (rst)
    fin_go && op == lcts_pkg::OP_COMPOSE |=> out_valid && !out_word.in_leap_unit)
    else $error("compose result carries leap flag");

endmodule

`default_nettype wire
